// ----- design/smc_pkg.sv -----
// ============================================================================
// smc_pkg
// Shared widths, codes and word types for the sphere containment and merge
// pipeline.
// ============================================================================
`default_nettype none

package smc_pkg;

	// Coordinate width and the widths derived from it.
	localparam int W    = 24;        // centre component width
	localparam int RW   = W - 1;     // radius width
	localparam int DW   = W + 1;     // centre difference width
	localparam int SQW  = 2 * DW;    // sum of squared differences
	localparam int LW   = DW;        // length (square root) width
	localparam int TW   = DW + 3;    // signed working width for t1, t2, s
	localparam int SMW  = DW + 1;    // magnitude of s
	localparam int NW   = DW + SMW;  // dividend width
	localparam int QW   = DW + 1;    // quotient bits kept
	localparam int VW   = QW + 2;    // signed width of a shifted centre
	localparam int DIV_LAT = QW + 1; // divider latency in cycles

	// Operation selector codes.
	localparam logic [1:0] FN_SPHERE = 2'd0;
	localparam logic [1:0] FN_POINT  = 2'd1;
	localparam logic [1:0] FN_MERGE  = 2'd2;
	// The spare selector gives an all-zero result.
	localparam logic [1:0] FN_NONE   = 2'd3;

	// Containment codes.
	localparam logic [1:0] CT_DISJOINT  = 2'd0;
	localparam logic [1:0] CT_INTERSECT = 2'd1;
	localparam logic [1:0] CT_CONTAIN   = 2'd2;

	// How the merge result is formed.
	typedef enum logic [1:0] {
		MG_ZERO,
		MG_A,
		MG_B,
		MG_FIT
	} mg_mode_t;

	// Input word.
	typedef struct packed {
		logic [1:0]          func;
		logic signed [W-1:0] a_center_x;
		logic signed [W-1:0] a_center_y;
		logic signed [W-1:0] a_center_z;
		logic [RW-1:0]       a_radius;
		logic signed [W-1:0] b_center_x;
		logic signed [W-1:0] b_center_y;
		logic signed [W-1:0] b_center_z;
		logic [RW-1:0]       b_radius;
	} in_t;

	// Output word.
	typedef struct packed {
		logic [1:0]          containment;
		logic signed [W-1:0] merged_x;
		logic signed [W-1:0] merged_y;
		logic signed [W-1:0] merged_z;
		logic [RW-1:0]       merged_radius;
		logic                saturated;
	} out_t;

	// Geometry carried alongside the square root.
	typedef struct packed {
		logic [1:0]           func;
		logic [2:0][W-1:0]    ca;
		logic [2:0][W-1:0]    cb;
		logic [2:0][DW-1:0]   dif;
		logic [RW-1:0]        ra;
		logic [RW-1:0]        rb;
	} geo_t;

	// Merge context carried alongside the dividers.
	typedef struct packed {
		logic [1:0]           cont;
		mg_mode_t             mode;
		logic [2:0][W-1:0]    ca;
		logic [2:0][W-1:0]    cb;
		logic [2:0]           neg;
		logic [RW-1:0]        ra;
		logic [RW-1:0]        rb;
		logic [RW-1:0]        rad;
		logic                 rsat;
	} mrg_t;

endpackage

`default_nettype wire

// ----- design/smc_sqrt.sv -----
// ============================================================================
// smc_sqrt
// Pipelined floor square root, one result bit per stage, with the geometry
// of each item travelling beside it.
// ============================================================================
`default_nettype none

module smc_sqrt (
	input  wire                      clk,
	input  wire                      arst_n,
	input  wire                      en,
	input  wire                      in_valid,
	input  wire [smc_pkg::SQW-1:0]   in_sum,
	input  smc_pkg::geo_t            in_geo,
	output logic                     out_valid,
	output logic [smc_pkg::LW-1:0]   out_len,
	output smc_pkg::geo_t            out_geo
);

	localparam int LW  = smc_pkg::LW;
	localparam int SQW = smc_pkg::SQW;

	logic [LW-1:0]       v_q;
	logic [SQW-1:0]      rem_q   [LW];
	logic [LW-1:0]       root_q  [LW];
	smc_pkg::geo_t       geo_q   [LW];

	logic [SQW-1:0]      rem_in  [LW];
	logic [LW-1:0]       root_in [LW];
	logic [SQW-1:0]      trial   [LW];
	logic [SQW-1:0]      rem_nx  [LW];
	logic [LW-1:0]       root_nx [LW];

	// Each stage tries the next lower root bit against the remainder.
	always_comb begin
		rem_in[0]  = in_sum;
		root_in[0] = '0;
		for (int k = 1; k < LW; k++) begin
			rem_in[k]  = rem_q[k-1];
			root_in[k] = root_q[k-1];
		end
		for (int k = 0; k < LW; k++) begin
			trial[k] = (SQW'(root_in[k]) << (LW - k)) | (SQW'(1) << (2 * (LW - 1 - k)));
			if (rem_in[k] >= trial[k]) begin
				rem_nx[k]  = rem_in[k] - trial[k];
				root_nx[k] = root_in[k] | (LW'(1) << (LW - 1 - k));
			end else begin
				rem_nx[k]  = rem_in[k];
				root_nx[k] = root_in[k];
			end
		end
	end

	// Valid bits of the stages.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= '0;
		end else if (en) begin
			v_q <= {v_q[LW-2:0], in_valid};
		end
	end

	// Stage data.
	always_ff @(posedge clk) begin
		if (en) begin
			for (int k = 0; k < LW; k++) begin
				rem_q[k]  <= rem_nx[k];
				root_q[k] <= root_nx[k];
			end
			geo_q[0] <= in_geo;
			for (int k = 1; k < LW; k++) begin
				geo_q[k] <= geo_q[k-1];
			end
		end
	end

	assign out_valid = v_q[LW-1];
	assign out_len   = root_q[LW-1];
	assign out_geo   = geo_q[LW-1];

endmodule

`default_nettype wire

// ----- design/smc_div.sv -----
// ============================================================================
// smc_div
// Pipelined restoring divider, one quotient bit per stage, with the
// quotient saturated when it would not fit.
// ============================================================================
`default_nettype none

module smc_div (
	input  wire                      clk,
	input  wire                      en,
	input  wire [smc_pkg::NW-1:0]    num,
	input  wire [smc_pkg::LW-1:0]    den,
	output logic [smc_pkg::QW-1:0]   quo
);

	localparam int LW = smc_pkg::LW;
	localparam int QW = smc_pkg::QW;
	localparam int NW = smc_pkg::NW;

	logic [LW-1:0]   rem0_q;
	logic [QW-1:0]   low0_q;
	logic [LW-1:0]   den0_q;
	logic            ovf0_q;

	logic [LW-1:0]   rem_q [QW];
	logic [QW-1:0]   low_q [QW];
	logic [QW-1:0]   quo_q [QW];
	logic [LW-1:0]   den_q [QW];
	logic            ovf_q [QW];

	logic [LW-1:0]   rem_in [QW];
	logic [QW-1:0]   low_in [QW];
	logic [QW-1:0]   quo_in [QW];
	logic [LW-1:0]   den_in [QW];
	logic            ovf_in [QW];
	logic [LW:0]     part   [QW];
	logic [LW-1:0]   rem_nx [QW];
	logic [QW-1:0]   quo_nx [QW];

	// Stage inputs and one restoring step per stage.
	always_comb begin
		rem_in[0] = rem0_q;
		low_in[0] = low0_q;
		quo_in[0] = '0;
		den_in[0] = den0_q;
		ovf_in[0] = ovf0_q;
		for (int k = 1; k < QW; k++) begin
			rem_in[k] = rem_q[k-1];
			low_in[k] = low_q[k-1];
			quo_in[k] = quo_q[k-1];
			den_in[k] = den_q[k-1];
			ovf_in[k] = ovf_q[k-1];
		end
		for (int k = 0; k < QW; k++) begin
			part[k] = {rem_in[k], low_in[k][QW-1]};
			if (part[k] >= {1'b0, den_in[k]}) begin
				rem_nx[k] = LW'(part[k] - {1'b0, den_in[k]});
				quo_nx[k] = {quo_in[k][QW-2:0], 1'b1};
			end else begin
				rem_nx[k] = part[k][LW-1:0];
				quo_nx[k] = {quo_in[k][QW-2:0], 1'b0};
			end
		end
	end

	// Front stage checks whether the quotient fits, then the bit stages.
	always_ff @(posedge clk) begin
		if (en) begin
			rem0_q <= num[NW-1:QW];
			low0_q <= num[QW-1:0];
			den0_q <= den;
			ovf0_q <= (num[NW-1:QW] >= den);
			for (int k = 0; k < QW; k++) begin
				rem_q[k] <= rem_nx[k];
				low_q[k] <= {low_in[k][QW-2:0], 1'b0};
				quo_q[k] <= quo_nx[k];
				den_q[k] <= den_in[k];
				ovf_q[k] <= ovf_in[k];
			end
		end
	end

	assign quo = ovf_q[QW-1] ? {QW{1'b1}} : quo_q[QW-1];

endmodule

`default_nettype wire

// ----- design/sphere_contain_and_merge_top.sv -----
// ============================================================================
// sphere_contain_and_merge_top
// Containment test and merge of two bounding spheres in fixed point.
// ============================================================================
// Usage:
// A word on the input channel (in_valid/in_ready/in_data) carries spheres A
// and B and an operation selector; each word yields exactly one word on the
// output channel (out_valid/out_ready/out_data), in order.
// From acceptance to out_valid a word passes the registers that form the
// centre differences, the squares and their sum, the square-root stages (one
// bit per stage), the merge set-up and multiply registers, the divider stages
// (one quotient bit per stage) and the output register.
// Throughput is one word per cycle while the output is not stalled; the
// bit-serial square root and divider stages set the depth, not the rate.
// The whole pipeline advances together whenever the output register is free
// or being taken. While the receiver stalls with a word waiting, every stage
// holds and in_ready is low; nothing is lost or repeated.
// Reset clears all valid bits, so the pipeline comes up empty.
// ============================================================================
`default_nettype none

module sphere_contain_and_merge_top (
	input  wire            clk,
	input  wire            arst_n,
	input  wire            in_valid,
	output logic           in_ready,
	input  smc_pkg::in_t   in_data,
	output logic           out_valid,
	input  wire            out_ready,
	output smc_pkg::out_t  out_data
);

	localparam int W   = smc_pkg::W;
	localparam int RW  = smc_pkg::RW;
	localparam int DW  = smc_pkg::DW;
	localparam int SQW = smc_pkg::SQW;
	localparam int LW  = smc_pkg::LW;
	localparam int TW  = smc_pkg::TW;
	localparam int SMW = smc_pkg::SMW;
	localparam int NW  = smc_pkg::NW;
	localparam int QW  = smc_pkg::QW;
	localparam int VW  = smc_pkg::VW;
	localparam int DL  = smc_pkg::DIV_LAT;

	localparam logic signed [VW-1:0] V_MAX = {{(VW-W+1){1'b0}}, {(W-1){1'b1}}};
	localparam logic signed [VW-1:0] V_MIN = ~V_MAX;
	localparam logic signed [TW-1:0] R_MAX = {{(TW-RW){1'b0}}, {RW{1'b1}}};

	logic                en;

	logic                v_s1, v_s2, v_s3, v_s4, v_s5;
	smc_pkg::geo_t       geo_s1, geo_s2, geo_s3;
	smc_pkg::geo_t       geo_in;
	logic [SQW-1:0]      sq_s2 [3];
	logic [SQW-1:0]      sum_s3;

	logic                sq_valid;
	logic [LW-1:0]       sq_len;
	smc_pkg::geo_t       sq_geo;

	smc_pkg::mrg_t       m_nx, m_s4, m_s5;
	logic [LW-1:0]       len_s4, len_s5;
	logic [SMW-1:0]      smag_s4;
	logic [DW-1:0]       dmag_s4 [3];
	logic [NW-1:0]       prod_s5 [3];

	logic [DL-1:0]       dv_q;
	smc_pkg::mrg_t       dm_q [DL];
	logic [QW-1:0]       quo [3];

	smc_pkg::out_t       out_nx, out_q;
	logic                out_valid_q;

	// The pipeline moves as one whenever the output register can take a word.
	assign en       = !out_valid_q || out_ready;
	assign in_ready = en;

	// Centre differences of the incoming word.
	always_comb begin
		geo_in.func  = in_data.func;
		geo_in.ca[0] = in_data.a_center_x;
		geo_in.ca[1] = in_data.a_center_y;
		geo_in.ca[2] = in_data.a_center_z;
		geo_in.cb[0] = in_data.b_center_x;
		geo_in.cb[1] = in_data.b_center_y;
		geo_in.cb[2] = in_data.b_center_z;
		geo_in.ra    = in_data.a_radius;
		geo_in.rb    = in_data.b_radius;
		for (int k = 0; k < 3; k++) begin
			geo_in.dif[k] = DW'($signed({geo_in.cb[k][W-1], geo_in.cb[k]})
				- $signed({geo_in.ca[k][W-1], geo_in.ca[k]}));
		end
	end

	// Front stages: differences, squares, sum.
	always_ff @(posedge clk) begin
		if (en) begin
			geo_s1 <= geo_in;
			geo_s2 <= geo_s1;
			for (int k = 0; k < 3; k++) begin
				sq_s2[k] <= SQW'((geo_s1.dif[k][DW-1] ? DW'(-geo_s1.dif[k]) : geo_s1.dif[k])
					* (geo_s1.dif[k][DW-1] ? DW'(-geo_s1.dif[k]) : geo_s1.dif[k]));
			end
			geo_s3 <= geo_s2;
			sum_s3 <= sq_s2[0] + sq_s2[1] + sq_s2[2];
		end
	end

	// Square root of the summed squares gives the centre distance.
	smc_sqrt u_sqrt (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (v_s3),
		.in_sum    (sum_s3),
		.in_geo    (geo_s3),
		.out_valid (sq_valid),
		.out_len   (sq_len),
		.out_geo   (sq_geo)
	);

	// Classification and merge set-up from the distance.
	logic signed [TW-1:0] ra_t, rb_t, len_t, t1, hi, t2, s_t;
	logic [TW-1:0]        s_mag;
	always_comb begin
		ra_t  = $signed({{(TW-RW){1'b0}}, sq_geo.ra});
		rb_t  = $signed({{(TW-RW){1'b0}}, sq_geo.rb});
		len_t = $signed({{(TW-LW){1'b0}}, sq_len});
		t1    = ((-ra_t) < (len_t - rb_t)) ? -ra_t : (len_t - rb_t);
		hi    = (ra_t > (len_t + rb_t)) ? ra_t : (len_t + rb_t);
		t2    = (hi - t1) >>> 1;
		s_t   = t1 + t2;
		s_mag = s_t[TW-1] ? TW'(-s_t) : TW'(s_t);

		m_nx.ca   = sq_geo.ca;
		m_nx.cb   = sq_geo.cb;
		m_nx.ra   = sq_geo.ra;
		m_nx.rb   = sq_geo.rb;
		m_nx.cont = smc_pkg::CT_DISJOINT;
		m_nx.mode = smc_pkg::MG_ZERO;
		for (int k = 0; k < 3; k++) begin
			m_nx.neg[k] = sq_geo.dif[k][DW-1] ^ s_t[TW-1];
		end
		if (t2 > R_MAX) begin
			m_nx.rad  = {RW{1'b1}};
			m_nx.rsat = 1'b1;
		end else begin
			m_nx.rad  = t2[RW-1:0];
			m_nx.rsat = 1'b0;
		end
		case (sq_geo.func)
			smc_pkg::FN_SPHERE: begin
				if ((ra_t + rb_t) < len_t) begin
					m_nx.cont = smc_pkg::CT_DISJOINT;
				end else if ((ra_t - rb_t) < len_t) begin
					m_nx.cont = smc_pkg::CT_INTERSECT;
				end else begin
					m_nx.cont = smc_pkg::CT_CONTAIN;
				end
			end
			smc_pkg::FN_POINT: begin
				m_nx.cont = (len_t >= ra_t) ? smc_pkg::CT_DISJOINT : smc_pkg::CT_CONTAIN;
			end
			smc_pkg::FN_MERGE: begin
				if ((ra_t + rb_t) >= len_t && (ra_t - rb_t) >= len_t) begin
					m_nx.mode = smc_pkg::MG_A;
				end else if ((ra_t + rb_t) >= len_t && (rb_t - ra_t) >= len_t) begin
					m_nx.mode = smc_pkg::MG_B;
				end else if (sq_len != '0) begin
					m_nx.mode = smc_pkg::MG_FIT;
				end
			end
			default: begin
				m_nx.cont = smc_pkg::CT_DISJOINT;
			end
		endcase
	end

	// Set-up register, then each axis difference magnitude times the shift magnitude.
	always_ff @(posedge clk) begin
		if (en) begin
			m_s4    <= m_nx;
			len_s4  <= sq_len;
			smag_s4 <= s_mag[SMW-1:0];
			for (int k = 0; k < 3; k++) begin
				dmag_s4[k] <= sq_geo.dif[k][DW-1] ? DW'(-sq_geo.dif[k]) : sq_geo.dif[k];
			end
			m_s5   <= m_s4;
			len_s5 <= len_s4;
			for (int k = 0; k < 3; k++) begin
				prod_s5[k] <= NW'(dmag_s4[k] * smag_s4);
			end
		end
	end

	// One divider per axis.
	for (genvar g = 0; g < 3; g++) begin : g_div
		smc_div u_div (
			.clk (clk),
			.en  (en),
			.num (prod_s5[g]),
			.den (len_s5),
			.quo (quo[g])
		);
	end

	// Merge context waits beside the dividers.
	always_ff @(posedge clk) begin
		if (en) begin
			dm_q[0] <= m_s5;
			for (int k = 1; k < DL; k++) begin
				dm_q[k] <= dm_q[k-1];
			end
		end
	end

	// Valid bits of the stages outside the square root.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1        <= 1'b0;
			v_s2        <= 1'b0;
			v_s3        <= 1'b0;
			v_s4        <= 1'b0;
			v_s5        <= 1'b0;
			dv_q        <= '0;
			out_valid_q <= 1'b0;
		end else if (en) begin
			v_s1        <= in_valid;
			v_s2        <= v_s1;
			v_s3        <= v_s2;
			v_s4        <= sq_valid;
			v_s5        <= v_s4;
			dv_q        <= {dv_q[DL-2:0], v_s5};
			out_valid_q <= dv_q[DL-1];
		end
	end

	// Final centres with clamping, and selection of the result.
	logic signed [VW-1:0] ca_v [3];
	logic signed [VW-1:0] q_v  [3];
	logic signed [VW-1:0] c_v  [3];
	logic [W-1:0]         c_f  [3];
	logic                 c_sat;
	always_comb begin
		c_sat = dm_q[DL-1].rsat;
		for (int k = 0; k < 3; k++) begin
			ca_v[k] = $signed({{(VW-W){dm_q[DL-1].ca[k][W-1]}}, dm_q[DL-1].ca[k]});
			q_v[k]  = $signed({{(VW-QW){1'b0}}, quo[k]});
			c_v[k]  = dm_q[DL-1].neg[k] ? (ca_v[k] - q_v[k]) : (ca_v[k] + q_v[k]);
			if (c_v[k] > V_MAX) begin
				c_f[k] = V_MAX[W-1:0];
				c_sat  = 1'b1;
			end else if (c_v[k] < V_MIN) begin
				c_f[k] = V_MIN[W-1:0];
				c_sat  = 1'b1;
			end else begin
				c_f[k] = c_v[k][W-1:0];
			end
		end

		out_nx.containment   = dm_q[DL-1].cont;
		out_nx.merged_x      = '0;
		out_nx.merged_y      = '0;
		out_nx.merged_z      = '0;
		out_nx.merged_radius = '0;
		out_nx.saturated     = 1'b0;
		case (dm_q[DL-1].mode)
			smc_pkg::MG_A: begin
				out_nx.merged_x      = dm_q[DL-1].ca[0];
				out_nx.merged_y      = dm_q[DL-1].ca[1];
				out_nx.merged_z      = dm_q[DL-1].ca[2];
				out_nx.merged_radius = dm_q[DL-1].ra;
			end
			smc_pkg::MG_B: begin
				out_nx.merged_x      = dm_q[DL-1].cb[0];
				out_nx.merged_y      = dm_q[DL-1].cb[1];
				out_nx.merged_z      = dm_q[DL-1].cb[2];
				out_nx.merged_radius = dm_q[DL-1].rb;
			end
			smc_pkg::MG_FIT: begin
				out_nx.merged_x      = c_f[0];
				out_nx.merged_y      = c_f[1];
				out_nx.merged_z      = c_f[2];
				out_nx.merged_radius = dm_q[DL-1].rad;
				out_nx.saturated     = c_sat;
			end
			default: begin
				out_nx.saturated = 1'b0;
			end
		endcase
	end

	// Output register.
	always_ff @(posedge clk) begin
		if (en) begin
			out_q <= out_nx;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

endmodule

`default_nettype wire

// ----- bench/tb.sv -----
// ============================================================================
// tb
// Self-checking bench for the sphere containment and merge pipeline. A
// queued driver and a clocked monitor exercise the valid/ready channels
// under several idling phases and one long output hold-off. Every result
// word is compared field by field with a behavioural prediction.
// ============================================================================
`default_nettype none

module tb;

	localparam int PERIOD    = 12;
	localparam int LIMIT     = 400000;
	localparam int N_RANDOM  = 1080;
	localparam int DRAIN     = 80;
	localparam int HOLD_LEN  = 400;
	localparam int W         = smc_pkg::W;
	localparam int RW        = smc_pkg::RW;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	smc_pkg::in_t  in_data = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	smc_pkg::out_t out_data;

	smc_pkg::in_t  pending_words[$];
	smc_pkg::out_t expected_words[$];
	int   n_accepted = 0;
	int   n_errors = 0;
	int   cycles = 0;
	int   hold_left = 0;
	bit   hold_done = 1'b0;
	int   send_pct, recv_pct;

	sphere_contain_and_merge_top uut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
		.out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
	);

	initial begin
		forever #(PERIOD / 2) clk = ~clk;
	end

	// Expected result of one input word.
	function automatic smc_pkg::out_t sphere_predict(smc_pkg::in_t w);
		longint ca[3], cb[3], dif[3];
		longint ra, rb, len, sum, c, t1, t2, hi, s, q, v, ad, as;
		longint cmin, cmax;
		logic sat;
		smc_pkg::out_t r;
		cmin = -(longint'(1) <<< (W - 1));
		cmax = (longint'(1) <<< (W - 1)) - 1;
		r = '0;
		sat = 1'b0;
		ca[0] = longint'(w.a_center_x);
		ca[1] = longint'(w.a_center_y);
		ca[2] = longint'(w.a_center_z);
		cb[0] = longint'(w.b_center_x);
		cb[1] = longint'(w.b_center_y);
		cb[2] = longint'(w.b_center_z);
		ra = longint'(w.a_radius);
		rb = longint'(w.b_radius);
		sum = 0;
		for (int k = 0; k < 3; k++) begin
			dif[k] = cb[k] - ca[k];
			sum += dif[k] * dif[k];
		end
		len = 0;
		for (int b = 25; b >= 0; b--) begin
			c = len | (longint'(1) <<< b);
			if (c * c <= sum)
				len = c;
		end
		case (w.func)
			smc_pkg::FN_SPHERE: begin
				if (ra + rb < len)
					r.containment = smc_pkg::CT_DISJOINT;
				else if (ra - rb < len)
					r.containment = smc_pkg::CT_INTERSECT;
				else
					r.containment = smc_pkg::CT_CONTAIN;
			end
			smc_pkg::FN_POINT: begin
				r.containment = (len >= ra) ? smc_pkg::CT_DISJOINT : smc_pkg::CT_CONTAIN;
			end
			smc_pkg::FN_MERGE: begin
				if (ra + rb >= len && ra - rb >= len) begin
					r.merged_x = W'(ca[0]); r.merged_y = W'(ca[1]); r.merged_z = W'(ca[2]);
					r.merged_radius = RW'(ra);
				end else if (ra + rb >= len && rb - ra >= len) begin
					r.merged_x = W'(cb[0]); r.merged_y = W'(cb[1]); r.merged_z = W'(cb[2]);
					r.merged_radius = RW'(rb);
				end else if (len > 0) begin
					t1 = (-ra < len - rb) ? -ra : len - rb;
					hi = (ra > len + rb) ? ra : len + rb;
					t2 = (hi - t1) >>> 1;
					s = t1 + t2;
					as = (s < 0) ? -s : s;
					for (int k = 0; k < 3; k++) begin
						ad = (dif[k] < 0) ? -dif[k] : dif[k];
						q = (ad * as) / len;
						if (q > (longint'(1) <<< 40))
							q = longint'(1) <<< 40;
						v = ((dif[k] < 0) != (s < 0)) ? ca[k] - q : ca[k] + q;
						if (v < cmin) begin v = cmin; sat = 1'b1; end
						if (v > cmax) begin v = cmax; sat = 1'b1; end
						if (k == 0) r.merged_x = W'(v);
						else if (k == 1) r.merged_y = W'(v);
						else r.merged_z = W'(v);
					end
					if (t2 > cmax) begin t2 = cmax; sat = 1'b1; end
					r.merged_radius = RW'(t2);
					r.saturated = sat;
				end
			end
			default: ;
		endcase
		return r;
	endfunction

	function automatic smc_pkg::in_t make_word(logic [1:0] fn, longint ax, longint ay,
			longint az, longint ar, longint bx, longint by, longint bz, longint br);
		smc_pkg::in_t w;
		w.func = fn;
		w.a_center_x = W'(ax); w.a_center_y = W'(ay); w.a_center_z = W'(az);
		w.a_radius = RW'(ar);
		w.b_center_x = W'(bx); w.b_center_y = W'(by); w.b_center_z = W'(bz);
		w.b_radius = RW'(br);
		return w;
	endfunction

	// Random radius: mostly modest, sometimes full range.
	function automatic longint rand_radius();
		case ($urandom_range(0, 3))
			0: return $urandom_range(0, 255);
			1: return $urandom_range(0, 65535);
			2: return $urandom_range(0, 1 << 20);
			default: return $urandom & 24'h7FFFFF;
		endcase
	endfunction

	// Phase of idling follows progress through the stimulus: none, sender,
	// receiver, then both at a lighter rate.
	always_comb begin
		int phase;
		phase = (n_accepted / 128) % 4;
		send_pct = (phase == 1) ? 77 : ((phase == 3) ? 23 : 0);
		recv_pct = (phase == 2) ? 77 : ((phase == 3) ? 23 : 0);
	end

	// Driver: offers queued words, holding each until accepted.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			in_data <= '0;
		end else begin
			if (in_valid && in_ready) begin
				expected_words.push_back(sphere_predict(in_data));
				n_accepted <= n_accepted + 1;
			end
			if (!in_valid || in_ready) begin
				if (pending_words.size() > 0 && !($urandom_range(0, 99) < send_pct)) begin
					in_valid <= 1'b1;
					in_data <= pending_words.pop_front();
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// One long receiver hold-off, counted in cycles.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hold_done <= 1'b0;
			hold_left <= 0;
		end else if (!hold_done && n_accepted >= 60) begin
			hold_done <= 1'b1;
			hold_left <= HOLD_LEN;
		end else if (hold_left > 0) begin
			hold_left <= hold_left - 1;
		end
	end

	// Monitor: checks each taken word and drives out_ready.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else begin
			if (out_valid && out_ready) begin
				if (expected_words.size() == 0) begin
					$error("unexpected word %h", out_data);
					n_errors++;
				end else begin
					smc_pkg::out_t e;
					e = expected_words.pop_front();
					if (out_data.containment !== e.containment) begin
						$error("containment exp %0d got %0d", e.containment, out_data.containment);
						n_errors++;
					end
					if (out_data.merged_x !== e.merged_x) begin
						$error("merged_x exp %0d got %0d", e.merged_x, out_data.merged_x);
						n_errors++;
					end
					if (out_data.merged_y !== e.merged_y) begin
						$error("merged_y exp %0d got %0d", e.merged_y, out_data.merged_y);
						n_errors++;
					end
					if (out_data.merged_z !== e.merged_z) begin
						$error("merged_z exp %0d got %0d", e.merged_z, out_data.merged_z);
						n_errors++;
					end
					if (out_data.merged_radius !== e.merged_radius) begin
						$error("merged_radius exp %0d got %0d", e.merged_radius,
							out_data.merged_radius);
						n_errors++;
					end
					if (out_data.saturated !== e.saturated) begin
						$error("saturated exp %0d got %0d", e.saturated, out_data.saturated);
						n_errors++;
					end
				end
			end
			if ((!hold_done && n_accepted >= 60) || hold_left > 0) begin
				out_ready <= 1'b0;
			end else begin
				out_ready <= !($urandom_range(0, 99) < recv_pct);
			end
		end
	end

	// Watchdog on the whole run.
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == LIMIT) begin
			$display("tb failed");
			$finish;
		end
	end

	// Stimulus and end of run.
	initial begin
		longint mx, mn;
		logic [1:0] fn;
		smc_pkg::in_t w;
		mx = (longint'(1) <<< 23) - 1;
		mn = -(longint'(1) <<< 23);
		// Directed words: extremes, each operation and the merge cases.
		pending_words.push_back(make_word(smc_pkg::FN_SPHERE, 0, 0, 0, 0, 0, 0, 0, 0));
		pending_words.push_back(make_word(smc_pkg::FN_POINT, 0, 0, 0, 0, 0, 0, 0, 0));
		pending_words.push_back(make_word(smc_pkg::FN_MERGE, 0, 0, 0, 0, 0, 0, 0, 0));
		pending_words.push_back(make_word(smc_pkg::FN_NONE, mx, mn, mx, mx, mn, mx, mn, mx));
		pending_words.push_back(make_word(smc_pkg::FN_SPHERE, mn, mn, mn, mx, mx, mx, mx, mx));
		pending_words.push_back(make_word(smc_pkg::FN_SPHERE, mn, mn, mn, 0, mx, mx, mx, 0));
		pending_words.push_back(make_word(smc_pkg::FN_SPHERE, 0, 0, 0, 1000, 300, 0, 0, 200));
		pending_words.push_back(make_word(smc_pkg::FN_SPHERE, 0, 0, 0, 1000, 900, 0, 0, 200));
		pending_words.push_back(make_word(smc_pkg::FN_SPHERE, 0, 0, 0, 100, 900, 0, 0, 200));
		pending_words.push_back(make_word(smc_pkg::FN_POINT, 0, 0, 0, 500, 499, 0, 0, 77));
		pending_words.push_back(make_word(smc_pkg::FN_POINT, 0, 0, 0, 500, 500, 0, 0, 77));
		pending_words.push_back(make_word(smc_pkg::FN_POINT, mx, mx, mx, mx, mn, mn, mn, 0));
		pending_words.push_back(make_word(smc_pkg::FN_MERGE, 0, 0, 0, 1000, 100, 0, 0, 50));
		pending_words.push_back(make_word(smc_pkg::FN_MERGE, 0, 0, 0, 50, 100, 0, 0, 1000));
		pending_words.push_back(make_word(smc_pkg::FN_MERGE, 0, 0, 0, 300, 1000, 500, -200,
			400));
		pending_words.push_back(make_word(smc_pkg::FN_MERGE, -256, 512, 0, 10, 256, -512, 3, 7));
		pending_words.push_back(make_word(smc_pkg::FN_MERGE, mn, mn, mn, mx, mx, mx, mx, mx));
		pending_words.push_back(make_word(smc_pkg::FN_MERGE, mn, mn, mn, 0, mx, mx, mx, 0));
		pending_words.push_back(make_word(smc_pkg::FN_MERGE, mx, 0, mn, mx, mn, 0, mx, 5));
		pending_words.push_back(make_word(smc_pkg::FN_MERGE, 5, 5, 5, 0, 5, 5, 5, 0));
		pending_words.push_back(make_word(smc_pkg::FN_MERGE, 0, 0, 0, 3, 1, 1, 1, 0));
		// Random words: mostly nearby pairs, some anywhere in range.
		for (int i = 0; i < N_RANDOM; i++) begin
			fn = ($urandom_range(0, 39) == 0) ? smc_pkg::FN_NONE : 2'($urandom_range(0, 2));
			w = smc_pkg::in_t'({$urandom, $urandom, $urandom, $urandom, $urandom, $urandom});
			w.func = fn;
			if ($urandom_range(0, 3) != 0) begin
				longint sp;
				sp = longint'(1) <<< $urandom_range(2, 22);
				w.a_radius = RW'(rand_radius());
				w.b_radius = RW'(rand_radius());
				w.b_center_x = W'(longint'(w.a_center_x) + longint'($urandom % sp) - sp / 2);
				w.b_center_y = W'(longint'(w.a_center_y) + longint'($urandom % sp) - sp / 2);
				w.b_center_z = W'(longint'(w.a_center_z) + longint'($urandom % sp) - sp / 2);
			end
			pending_words.push_back(w);
		end
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		// Wait for every word to go in and every result to come back.
		do
			@(posedge clk);
		while (pending_words.size() > 0 || in_valid || expected_words.size() > 0);
		repeat (DRAIN) @(posedge clk);
		if (n_errors == 0 && expected_words.size() == 0)
			$display("tb passed");
		else
			$display("tb failed");
		$finish;
	end

endmodule

`default_nettype wire

// ----- sphere_contain_and_merge_top.f -----
design/smc_pkg.sv
design/smc_sqrt.sv
design/smc_div.sv
design/sphere_contain_and_merge_top.sv
bench/tb.sv
